[hw/rtl/rcpa_pkg.sv]
// ----------------------------------------------------------------------------
// rcpa_pkg - shared types and constants of the page allocator
// Pool geometry, operation and status codes, the queued item and helpers.
// ----------------------------------------------------------------------------
package rcpa_pkg;

    // Pool geometry
    localparam int NUM_PAGES       = 32768;
    localparam int FIRST_FREE_PAGE = 256;
    localparam int COUNT_WIDTH     = 8;

    // Fixed field widths of the ports
    localparam int PAGE_W      = 15;
    localparam int PAGE_W1     = PAGE_W + 1;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 8;

    // Page numbers stay below 2^PAGE_W
    localparam int PAGE_TOP = (NUM_PAGES < (1 << PAGE_W)) ? NUM_PAGES : (1 << PAGE_W);
    localparam int PAGE_AW  = $clog2(PAGE_TOP);

    localparam bit POOL_INIT_EMPTY = (FIRST_FREE_PAGE >= PAGE_TOP);

    typedef logic [PAGE_W-1:0]      t_page;
    typedef logic [PAGE_AW-1:0]     t_idx;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_page  HEAD_INIT = POOL_INIT_EMPTY ? '0 : PAGE_W'(PAGE_TOP - 1);
    localparam t_count COUNT_MAX = '1;
    localparam t_count COUNT_ONE = COUNT_WIDTH'(1);
    localparam t_idx   IDX_LAST  = PAGE_AW'(PAGE_TOP - 1);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADDREF  = 2'd2,
        OP_COW     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_BAD   = 3'd2,
        ST_OVF   = 3'd3,
        ST_FREE  = 3'd4
    } t_status;

    // Classified word as it waits in the queue
    typedef struct packed {
        t_op   op;
        t_page page;
        logic  bad;
    } t_item;

    // Queue state seen by the back end
    typedef struct packed {
        logic  avail;
        t_item head;
    } t_q_status;

    // Page outside the usable range
    function automatic logic page_bad(input t_page p);
        logic [PAGE_W1-1:0] w;
        w = {1'b0, p};
        return (w < PAGE_W1'(FIRST_FREE_PAGE)) || (w >= PAGE_W1'(PAGE_TOP));
    endfunction

    // Low bits of a count as reported on the port
    function automatic logic [COUNT_OUT_W-1:0] count_low(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return w[COUNT_OUT_W-1:0];
    endfunction

endpackage

[hw/rtl/rcpa_front.sv]
// ----------------------------------------------------------------------------
// rcpa_front - command intake
// Takes commands, flags out-of-range pages and holds them in a short queue.
// ----------------------------------------------------------------------------
module rcpa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  rcpa_pkg::t_page    i_page_number,
    input  logic               i_clearing,
    input  logic               i_pop,
    output rcpa_pkg::t_q_status o_q
);
    import rcpa_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_fill, n_fill;
    logic            push;
    t_item           item;

    // Hold off while the memories are cleared or the queue is full
    assign busy = i_clearing || (r_fill == Q_CW'(Q_DEPTH));
    assign push = start && !busy;

    // Classify the incoming word
    always_comb begin
        item.op   = t_op'(i_op);
        item.page = i_page_number;
        item.bad  = (item.op != OP_ALLOC) && page_bad(i_page_number);
    end

    // Queue pointers and fill level
    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill + Q_CW'(push) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    assign o_q.avail = (r_fill != '0);
    assign o_q.head  = r_q[r_rd_ptr];

endmodule

[hw/rtl/rcpa_back.sv]
// ----------------------------------------------------------------------------
// rcpa_back - allocator execute unit
// Owns the free-list head, link and count memories; runs one word at a time.
// ----------------------------------------------------------------------------
module rcpa_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rcpa_pkg::t_q_status        i_q,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_result_valid,
    output rcpa_pkg::t_page            o_result_page,
    output rcpa_pkg::t_status          o_status,
    output logic                       o_page_released,
    output logic                       o_copy_needed,
    output logic [rcpa_pkg::COUNT_OUT_W-1:0] o_count_after
);
    import rcpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FIX   = 4'b1000
    } t_bstate;

    // Memories
    t_count count_mem [PAGE_TOP];
    t_idx   link_mem  [PAGE_TOP];

    t_bstate r_state, n_state;
    t_idx    r_clr, n_clr;
    t_page   r_head, n_head;
    logic    r_empty, n_empty;
    t_item   r_item;
    t_count  r_cnt;
    t_idx    r_link;
    t_idx    r_fix_idx, n_fix_idx;
    t_count  r_fix_cnt, n_fix_cnt;

    logic                   r_res_valid, n_res_valid;
    t_page                  r_res_page, n_res_page;
    t_status                r_status, n_status;
    logic                   r_released, n_released;
    logic                   r_copy, n_copy;
    logic [COUNT_OUT_W-1:0] r_count_after;
    t_count                 n_count;

    logic   cnt_we, link_we;
    t_idx   cnt_addr, link_addr;
    t_count cnt_wdata;
    t_idx   link_wdata;
    t_idx   pg_idx, head_idx, q_idx;
    t_count cnt_dec;

    assign o_pop      = (r_state == S_IDLE) && i_q.avail;
    assign o_clearing = (r_state == S_CLEAR);

    assign pg_idx   = r_item.page[PAGE_AW-1:0];
    assign head_idx = r_head[PAGE_AW-1:0];
    assign q_idx    = i_q.head.page[PAGE_AW-1:0];
    assign cnt_dec  = r_cnt - COUNT_ONE;

    // Sequencer and operation decode
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_head      = r_head;
        n_empty     = r_empty;
        n_fix_idx   = r_fix_idx;
        n_fix_cnt   = r_fix_cnt;
        n_res_valid = 1'b0;
        n_res_page  = r_res_page;
        n_status    = r_status;
        n_released  = r_released;
        n_copy      = r_copy;
        n_count     = '0;
        cnt_we      = 1'b0;
        cnt_addr    = pg_idx;
        cnt_wdata   = '0;
        link_we     = 1'b0;
        link_addr   = pg_idx;
        link_wdata  = head_idx;

        unique case (r_state)
            S_CLEAR: begin
                // counts to zero, each usable page links to the one below, the lowest to itself
                cnt_we    = 1'b1;
                cnt_addr  = r_clr;
                link_we   = 1'b1;
                link_addr = r_clr;
                if (PAGE_W1'(r_clr) > PAGE_W1'(FIRST_FREE_PAGE)) begin
                    link_wdata = r_clr - 1'b1;
                end else begin
                    link_wdata = r_clr;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_valid = 1'b1;
                n_res_page  = '0;
                n_status    = ST_OK;
                n_released  = 1'b0;
                n_copy      = 1'b0;
                n_state     = S_IDLE;
                if (r_item.op == OP_ALLOC) begin
                    if (r_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_res_page = r_head;
                        n_count    = COUNT_ONE;
                        cnt_we     = 1'b1;
                        cnt_addr   = head_idx;
                        cnt_wdata  = COUNT_ONE;
                        // self link marks the list end
                        if (r_link == head_idx) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = PAGE_W'(r_link);
                        end
                    end
                end else if (r_item.bad) begin
                    n_status = ST_BAD;
                end else if (r_item.op == OP_RELEASE) begin
                    n_count = r_cnt;
                    if (r_cnt == '0) begin
                        n_status = ST_FREE;
                    end else begin
                        n_count   = cnt_dec;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_dec;
                        if (cnt_dec == '0) begin
                            // push the page onto the free list
                            link_we    = 1'b1;
                            link_wdata = r_empty ? pg_idx : head_idx;
                            n_head     = r_item.page;
                            n_empty    = 1'b0;
                            n_released = 1'b1;
                        end
                    end
                end else if (r_item.op == OP_ADDREF) begin
                    n_count = r_cnt;
                    if (r_cnt == '0) begin
                        n_status = ST_FREE;
                    end else if (r_cnt == COUNT_MAX) begin
                        n_status = ST_OVF;
                    end else begin
                        n_count   = r_cnt + COUNT_ONE;
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt + COUNT_ONE;
                    end
                end else begin
                    // copy-on-write
                    n_count = r_cnt;
                    if (r_cnt <= COUNT_ONE) begin
                        n_res_page = r_item.page;
                    end else if (r_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_res_page = r_head;
                        n_count    = cnt_dec;
                        n_copy     = 1'b1;
                        cnt_we     = 1'b1;
                        cnt_addr   = head_idx;
                        cnt_wdata  = COUNT_ONE;
                        if (r_link == head_idx) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = PAGE_W'(r_link);
                        end
                        // old page count written on the next cycle
                        n_fix_idx = pg_idx;
                        n_fix_cnt = cnt_dec;
                        n_state   = S_FIX;
                    end
                end
            end
            S_FIX: begin
                cnt_we    = 1'b1;
                cnt_addr  = r_fix_idx;
                cnt_wdata = r_fix_cnt;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= HEAD_INIT;
            r_empty     <= POOL_INIT_EMPTY;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q.head;
        end
        r_fix_idx  <= n_fix_idx;
        r_fix_cnt  <= n_fix_cnt;
        r_res_page <= n_res_page;
        r_status   <= n_status;
        r_released <= n_released;
        r_copy     <= n_copy;
        if (r_state == S_EXEC) begin
            r_count_after <= count_low(n_count);
        end
    end

    // Count memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            count_mem[cnt_addr] <= cnt_wdata;
        end
        if (o_pop) begin
            r_cnt <= count_mem[q_idx];
        end
    end

    // Link memory: one write, one registered read at the list head
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_addr] <= link_wdata;
        end
        if (o_pop) begin
            r_link <= link_mem[head_idx];
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_result_page   = r_res_page;
    assign o_status        = r_status;
    assign o_page_released = r_released;
    assign o_copy_needed   = r_copy;
    assign o_count_after   = r_count_after;

endmodule

[hw/rtl/refcounted_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// refcounted_page_allocator_top - reference-counted page allocator
// LIFO free list of page numbers with a reference count per page.
// ----------------------------------------------------------------------------
// After reset the block sweeps its link and count memories, one page a cycle,
// over all PAGE_TOP pages (32768 with the default pool) and holds busy high
// meanwhile. A command is taken when start is high and busy is low; it goes
// into a two-entry queue and busy rises only when that queue is full. Each
// command then passes through the execute unit (registered memory read, then
// update), with an extra fix-up step for a copy-on-write that hands out a new page,
// because the count memory has a single write port and two counts change.
// Each command gives exactly one result word, shown for a single cycle with
// o_result_valid; the receiver cannot stall it.
module refcounted_page_allocator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [rcpa_pkg::PAGE_W-1:0]       i_page_number,
    output logic                              o_result_valid,
    output logic [rcpa_pkg::PAGE_W-1:0]       o_result_page,
    output logic [rcpa_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_page_released,
    output logic                              o_copy_needed,
    output logic [rcpa_pkg::COUNT_OUT_W-1:0]  o_count_after
);
    import rcpa_pkg::*;

    t_q_status q_status;
    logic      pop;
    logic      clearing;
    t_status   status;

    // Intake and queue
    rcpa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_page_number (i_page_number),
        .i_clearing    (clearing),
        .i_pop         (pop),
        .o_q           (q_status)
    );

    // Execute unit
    rcpa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q             (q_status),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_result_valid  (o_result_valid),
        .o_result_page   (o_result_page),
        .o_status        (status),
        .o_page_released (o_page_released),
        .o_copy_needed   (o_copy_needed),
        .o_count_after   (o_count_after)
    );

    assign o_status = status;

endmodule

[hw/rtl/rcpa_checker.sv]
// ----------------------------------------------------------------------------
// rcpa_checker - port-level checks of the page allocator
// Result spacing, consistency of result words, busy after reset.
// ----------------------------------------------------------------------------
module rcpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic [rcpa_pkg::PAGE_W-1:0]       o_result_page,
    input logic [rcpa_pkg::STATUS_W-1:0]     o_status,
    input logic                              o_page_released,
    input logic                              o_copy_needed,
    input logic [rcpa_pkg::COUNT_OUT_W-1:0]  o_count_after
);
    import rcpa_pkg::*;

    // Memory sweep starts straight out of reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> busy && !o_result_valid)
        else $error("busy low or result shown right after reset");

    // Execute unit needs a read step and an update step per word, so results never come back to back
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    // A refused command leaves no page and no side effect
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_OK) |->
            (o_result_page == '0) && !o_page_released && !o_copy_needed)
        else $error("failed command reports a page or side effect");

    // A page goes back to the pool only when its count hits zero
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_page_released |->
            (o_status == ST_OK) && (o_count_after == '0) && !o_copy_needed)
        else $error("release with non-zero count or bad status");

    // A copy always comes with a fresh page and ok status
    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_copy_needed |-> (o_status == ST_OK))
        else $error("copy requested on failed command");

endmodule

bind refcounted_page_allocator_top rcpa_checker u_rcpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_result_page   (o_result_page),
    .o_status        (o_status),
    .o_page_released (o_page_released),
    .o_copy_needed   (o_copy_needed),
    .o_count_after   (o_count_after)
);

[verif/page_allocator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_allocator_checker - result checker for the page allocator
// Watches the command and result channels, keeps its own copy of the free
// list and the reference counts, and compares every result word, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module page_allocator_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [1:0]                       i_op,
    input  logic [rcpa_pkg::PAGE_W-1:0]      i_page_number,
    input  logic                             i_result_valid,
    input  logic [rcpa_pkg::PAGE_W-1:0]      i_result_page,
    input  logic [rcpa_pkg::STATUS_W-1:0]    i_status,
    input  logic                             i_page_released,
    input  logic                             i_copy_needed,
    input  logic [rcpa_pkg::COUNT_OUT_W-1:0] i_count_after,
    output int                               o_fail_count,
    output int                               o_outstanding,
    output int                               o_words,
    output int                               o_checked
);
    import rcpa_pkg::*;

    // Expected content of one result word
    typedef struct packed {
        t_page                  page;
        t_status                status;
        logic                   released;
        logic                   copy;
        logic [COUNT_OUT_W-1:0] count;
    } t_outcome;

    // Only the first few mismatches are printed; all are counted
    localparam int REPORT_CAP = 32;

    // Shadow pool state
    t_count   count_tab [PAGE_TOP];
    t_page    link_tab  [PAGE_TOP];
    t_page    head_pg;
    logic     dry;

    t_outcome outcome_q [$];
    int       fails   = 0;
    int       words   = 0;
    int       checked = 0;

    // Usable page range
    function automatic bit in_pool(input t_page p);
        return int'(p) >= FIRST_FREE_PAGE && int'(p) < PAGE_TOP;
    endfunction

    // Pool after reset: descending list, lowest usable page ends on itself
    function automatic void reset_pool();
        for (int p = 0; p < PAGE_TOP; p++) begin
            count_tab[p] = '0;
            if (in_pool(t_page'(p))) begin
                link_tab[p] = (p > FIRST_FREE_PAGE) ? t_page'(p - 1) : t_page'(p);
            end else begin
                link_tab[p] = '0;
            end
        end
        dry     = (FIRST_FREE_PAGE >= PAGE_TOP);
        head_pg = dry ? '0 : t_page'(PAGE_TOP - 1);
    endfunction

    // Pop the head of the free list; caller has checked the pool is not dry
    function automatic t_page take_page();
        t_page p;
        p = head_pg;
        if (int'(p) >= PAGE_TOP) begin
            dry = 1'b1;
            return '0;
        end
        if (link_tab[p] == p) begin
            dry = 1'b1;
        end else begin
            head_pg = link_tab[p];
        end
        return p;
    endfunction

    // Apply one command to the shadow state and work out its result word
    function automatic t_outcome predict_outcome(input t_op op, input t_page pg);
        t_outcome r;
        int       c;
        r        = '0;
        r.status = ST_OK;
        c        = 0;
        if (op == OP_ALLOC) begin
            if (dry) begin
                r.status = ST_EMPTY;
            end else begin
                r.page = take_page();
                if (int'(r.page) < PAGE_TOP) count_tab[r.page] = COUNT_ONE;
                c = 1;
            end
        end else if (!in_pool(pg)) begin
            r.status = ST_BAD;
        end else begin
            c = int'(count_tab[pg]);
            case (op)
                OP_RELEASE: begin
                    if (c == 0) begin
                        r.status = ST_FREE;
                    end else begin
                        c--;
                        count_tab[pg] = t_count'(c);
                        // last reference gone: push; an empty list ends on itself
                        if (c == 0) begin
                            link_tab[pg] = dry ? pg : head_pg;
                            head_pg      = pg;
                            dry          = 1'b0;
                            r.released   = 1'b1;
                        end
                    end
                end
                OP_ADDREF: begin
                    if (c == 0) begin
                        r.status = ST_FREE;
                    end else if (c >= int'(COUNT_MAX)) begin
                        r.status = ST_OVF;
                    end else begin
                        c++;
                        count_tab[pg] = t_count'(c);
                    end
                end
                OP_COW: begin
                    if (c <= 1) begin
                        r.page = pg;
                    end else if (dry) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.page = take_page();
                        if (int'(r.page) < PAGE_TOP) count_tab[r.page] = COUNT_ONE;
                        c--;
                        count_tab[pg] = t_count'(c);
                        r.copy        = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.count = c[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fails < REPORT_CAP) begin
            $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
                     $time, checked, what, got, want);
        end
        fails++;
    endtask

    // Check result words first (they belong to older commands), then predict
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            reset_pool();
            outcome_q.delete();
        end else begin
            if (i_result_valid) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result word with nothing outstanding, page",
                                    int'(i_result_page), -1);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_result_page !== want.page)
                        report_mismatch("result_page", int'(i_result_page), int'(want.page));
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                    if (i_page_released !== want.released)
                        report_mismatch("page_released", int'(i_page_released),
                                        int'(want.released));
                    if (i_copy_needed !== want.copy)
                        report_mismatch("copy_needed", int'(i_copy_needed), int'(want.copy));
                    if (i_count_after !== want.count)
                        report_mismatch("count_after", int'(i_count_after), int'(want.count));
                end
                checked++;
            end
            if (i_start && !i_busy) begin
                outcome_q.push_back(predict_outcome(t_op'(i_op), i_page_number));
                words++;
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= outcome_q.size();
        o_words       <= words;
        o_checked     <= checked;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench top of the reference-counted page allocator
// Drives directed and random commands with random gaps and reports the
// verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;
    import rcpa_pkg::*;

    localparam int    HALF_HIGH      = 6;
    localparam int    HALF_LOW       = 6;
    localparam int    RESET_CYCLES   = 8;
    localparam int    RANDOM_WORDS   = 1576;
    localparam int    STEADY_FROM    = 700;
    localparam int    STEADY_TO      = 1200;
    localparam int    TAIL_CYCLES    = 12;
    // Post-reset sweep alone covers all PAGE_TOP pages with nothing taken
    localparam int    WATCHDOG_LIMIT = 4 * PAGE_TOP + 1000;
    localparam int    RING_SIZE      = 64;
    localparam t_page TOP_PAGE       = t_page'(PAGE_TOP - 1);
    localparam t_page LOW_PAGE       = t_page'(FIRST_FREE_PAGE);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             cmd_op;
    t_page                  cmd_page;
    logic                   o_result_valid;
    logic [PAGE_W-1:0]      o_result_page;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_page_released;
    logic                   o_copy_needed;
    logic [COUNT_OUT_W-1:0] o_count_after;

    int    fail_count;
    int    outstanding;
    int    words_taken;
    int    words_checked;

    // Pages recently handed out, used to aim commands at live pages
    t_page page_ring [RING_SIZE];
    int    ring_wr   = 0;
    int    ring_fill = 0;
    bit    steady    = 1'b0;
    int    quiet_cycles = 0;

    refcounted_page_allocator_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (cmd_op),
        .i_page_number   (cmd_page),
        .o_result_valid  (o_result_valid),
        .o_result_page   (o_result_page),
        .o_status        (o_status),
        .o_page_released (o_page_released),
        .o_copy_needed   (o_copy_needed),
        .o_count_after   (o_count_after)
    );

    page_allocator_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (cmd_op),
        .i_page_number   (cmd_page),
        .i_result_valid  (o_result_valid),
        .i_result_page   (o_result_page),
        .i_status        (o_status),
        .i_page_released (o_page_released),
        .i_copy_needed   (o_copy_needed),
        .i_count_after   (o_count_after),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_words         (words_taken),
        .o_checked       (words_checked)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #(HALF_LOW);
        i_clk = 1'b1;
        #(HALF_HIGH);
    end

    // Harvest live pages and guard against a hang
    always @(posedge i_clk) begin
        if (o_result_valid && o_status == ST_OK && int'(o_result_page) >= FIRST_FREE_PAGE) begin
            page_ring[ring_wr] <= o_result_page;
            ring_wr            <= (ring_wr + 1) % RING_SIZE;
            if (ring_fill < RING_SIZE) ring_fill <= ring_fill + 1;
        end
        if ((start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one command word from a falling edge until it is taken
    task automatic issue(input t_op op, input t_page pg);
        if (!steady && $urandom_range(0, 99) < 6) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start    <= 1'b1;
        cmd_op   <= op;
        cmd_page <= pg;
        do @(posedge i_clk); while (busy);
    endtask

    // Mostly live pages, some below the pool, some edges, some anywhere
    function automatic t_page pick_page();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55 && ring_fill > 0) return page_ring[$urandom_range(0, ring_fill - 1)];
        if (roll < 65) return t_page'($urandom_range(0, FIRST_FREE_PAGE - 1));
        if (roll < 70) begin
            case ($urandom_range(0, 3))
                0:       return LOW_PAGE;
                1:       return TOP_PAGE;
                2:       return '0;
                default: return t_page'(FIRST_FREE_PAGE - 1);
            endcase
        end
        return t_page'($urandom_range(0, PAGE_TOP - 1));
    endfunction

    task automatic random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            issue(OP_ALLOC, t_page'($urandom_range(0, PAGE_TOP - 1)));
        end else if (roll < 55) begin
            issue(OP_RELEASE, pick_page());
        end else if (roll < 78) begin
            issue(OP_ADDREF, pick_page());
        end else begin
            issue(OP_COW, pick_page());
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        cmd_op   = OP_ALLOC;
        cmd_page = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh pool hands out pages from the top down
        issue(OP_ALLOC, TOP_PAGE);
        issue(OP_ADDREF, TOP_PAGE);
        issue(OP_COW, TOP_PAGE);              // shared: new page, copy asked
        issue(OP_COW, TOP_PAGE);              // sole owner keeps the page
        issue(OP_COW, t_page'(1000));         // free page counts as unshared
        issue(OP_RELEASE, t_page'(1000));     // release of a free page refused
        issue(OP_ADDREF, t_page'(1000));      // no revival of a free page
        issue(OP_RELEASE, t_page'(TOP_PAGE - 1)); // back on the list
        issue(OP_ALLOC, '0);                  // same page again, LIFO
        issue(OP_RELEASE, '0);
        issue(OP_ADDREF, t_page'(FIRST_FREE_PAGE - 1));
        issue(OP_COW, t_page'(FIRST_FREE_PAGE - 1));
        issue(OP_RELEASE, LOW_PAGE);

        // Count overflow on a fresh page, then copy-on-write from it
        issue(OP_ALLOC, '1);
        repeat (int'(COUNT_MAX) - 1) issue(OP_ADDREF, t_page'(TOP_PAGE - 2));
        issue(OP_ADDREF, t_page'(TOP_PAGE - 2));
        issue(OP_COW, t_page'(TOP_PAGE - 2));
        issue(OP_RELEASE, t_page'(TOP_PAGE - 2));
        issue(OP_RELEASE, t_page'(TOP_PAGE - 3));
        issue(OP_RELEASE, t_page'(TOP_PAGE - 1));
        issue(OP_RELEASE, TOP_PAGE);

        // Random mix, with one stretch without gaps
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= STEADY_FROM && n < STEADY_TO);
            random_word();
        end
        steady = 1'b0;

        // Wind down
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d command words taken, %0d result words checked, %0d mismatches",
                 words_taken, words_checked, fail_count);
        $display("Covered all operations, bad and free pages, count overflow and shared copies");
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rcpa_pkg.sv
hw/rtl/rcpa_front.sv
hw/rtl/rcpa_back.sv
hw/rtl/refcounted_page_allocator_top.sv
hw/rtl/rcpa_checker.sv
verif/page_allocator_checker.sv
verif/tb.sv
